[rtl/idea_pkg.sv]
// ---------------------------------------------------------------------------
// IDEA package
// Shared constants and arithmetic helpers for the IDEA cipher and MAC block.
// ---------------------------------------------------------------------------
package idea_pkg;
  localparam int ROUNDS_DEF = 8;
  localparam logic [1:0] OP_ENC = 2'd0;
  localparam logic [1:0] OP_DEC = 2'd1;
  localparam logic [1:0] OP_MAC = 2'd2;
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  // multiply modulo 65537, zero stands for 65536
  function automatic logic [15:0] mulmod(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [15:0] lo, hi;
    p = 32'(a) * 32'(b);
    lo = p[15:0];
    hi = p[31:16];
    if (a == 16'd0) mulmod = 16'(17'd1 - 17'(b));
    else if (b == 16'd0) mulmod = 16'(17'd1 - 17'(a));
    else mulmod = 16'(lo - hi + ((lo < hi) ? 16'd1 : 16'd0));
  endfunction

  // modular product of two residues below 65537 held as 17-bit values
  function automatic logic [16:0] mulres(input logic [16:0] a, input logic [16:0] b);
    logic [15:0] ma, mb, m;
    ma = a[15:0];
    mb = b[15:0];
    m = mulmod(ma, mb);
    mulres = (m == 16'd0) ? 17'h10000 : {1'b0, m};
  endfunction
endpackage

[rtl/idea_inv.sv]
// ---------------------------------------------------------------------------
// IDEA inverse unit
// Computes x^65535 mod 65537 by square and multiply, one exponent bit per multiply-and-square pair.
// ---------------------------------------------------------------------------
module idea_inv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] x,
  output logic        done,
  output logic [15:0] y
);
  logic [16:0] r_r, b_r;
  logic [4:0]  cnt_r;
  logic        ph_r, busy_r, done_r, zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
      ph_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        ph_r   <= 1'b0;
        r_r    <= 17'd1;
        b_r    <= (x == 16'd0) ? 17'h10000 : {1'b0, x};
        zero_r <= (x == 16'd0);
      end else if (busy_r) begin
        // alternate multiply and square so each cycle has one multiplier
        if (!ph_r) r_r <= idea_pkg::mulres(r_r, b_r);
        else begin
          b_r   <= idea_pkg::mulres(b_r, b_r);
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
        ph_r <= ~ph_r;
      end
    end
  end

  assign done = done_r;
  assign y = zero_r ? 16'd0 : r_r[15:0];
endmodule

[rtl/idea_keymem.sv]
// ---------------------------------------------------------------------------
// IDEA subkey memory
// Encryption and decryption subkeys, one synchronous memory each, with a
// sequencer that rebuilds both schedules after reset and after a key write.
// ---------------------------------------------------------------------------
module idea_keymem #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         key_load,
  input  logic [127:0] key,
  input  logic         rd_en,
  input  logic [5:0]   rd_addr,
  input  logic         rd_dec,
  output logic [15:0]  rd_data,
  output logic         busy
);
  localparam int NSUB = 6 * ROUNDS + 4;

  typedef enum logic [2:0] {S_IDLE, S_EXP, S_DRD, S_DWAIT, S_DINV, S_DWR} st_t;

  logic [15:0] enc_mem [NSUB];
  logic [15:0] dec_mem [NSUB];
  st_t         st_r;
  logic [5:0]  i_r, d_r;
  logic [3:0]  q_r;
  logic [2:0]  m_r;
  logic [127:0] key_r, krot_r;
  logic        pend_r;
  logic        inv_start_r, inv_done;
  logic [15:0] inv_y, src_r, d_val_r;
  logic [1:0]  kind_r;

  // dec entry (round q, word m) -> source enc index and kind
  // (0 copy, 1 negate, 2 invert)
  function automatic logic [7:0] dmap(input logic [3:0] q, input logic [2:0] m);
    int e;
    logic [5:0] s;
    logic [1:0] k;
    e = 6 * (ROUNDS - int'(q));
    s = 6'd0;
    k = 2'd0;
    case (m)
      3'd0: begin s = 6'(e); k = 2'd2; end
      3'd1: begin s = 6'(((q == 4'd0) || (q == 4'(ROUNDS))) ? e + 1 : e + 2); k = 2'd1; end
      3'd2: begin s = 6'(((q == 4'd0) || (q == 4'(ROUNDS))) ? e + 2 : e + 1); k = 2'd1; end
      3'd3: begin s = 6'(e + 3); k = 2'd2; end
      3'd4: begin s = 6'(e - 2); k = 2'd0; end
      default: begin s = 6'(e - 1); k = 2'd0; end
    endcase
    dmap = {s, k};
  endfunction

  logic [7:0] dm;
  assign dm = dmap(q_r, m_r);

  idea_inv u_inv (
    .clk(clk), .rst_n(rst_n), .start(inv_start_r), .x(src_r),
    .done(inv_done), .y(inv_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_EXP;
      i_r         <= 6'd0;
      d_r         <= 6'd0;
      q_r         <= 4'd0;
      m_r         <= 3'd0;
      key_r       <= '0;
      krot_r      <= '0;
      pend_r      <= 1'b0;
      inv_start_r <= 1'b0;
    end else begin
      inv_start_r <= 1'b0;
      if (key_load) begin
        key_r  <= key;
        pend_r <= 1'b1;
      end
      case (st_r)
        S_IDLE: begin
          if (pend_r && !key_load) begin
            pend_r <= 1'b0;
            i_r    <= 6'd0;
            krot_r <= key_r;
            st_r   <= S_EXP;
          end
        end
        S_EXP: begin
          // take the top word; rotate by 16 within a group of eight and by 41
          // after its last word, so each group advances the key by 25 bits
          enc_mem[i_r] <= krot_r[127:112];
          if (i_r[2:0] == 3'd7) krot_r <= {krot_r[86:0], krot_r[127:87]};
          else krot_r <= {krot_r[111:0], krot_r[127:112]};
          if (i_r == 6'(NSUB - 1)) begin
            st_r <= S_DRD;
            d_r  <= 6'd0;
            q_r  <= 4'd0;
            m_r  <= 3'd0;
          end
          i_r <= i_r + 6'd1;
        end
        S_DRD: begin
          src_r  <= enc_mem[dm[7:2]];
          kind_r <= dm[1:0];
          st_r   <= S_DWAIT;
        end
        S_DWAIT: begin
          if (kind_r == 2'd2) begin
            inv_start_r <= 1'b1;
            st_r <= S_DINV;
          end else begin
            d_val_r <= (kind_r == 2'd1) ? 16'(17'd0 - 17'(src_r)) : src_r;
            st_r <= S_DWR;
          end
        end
        S_DINV: begin
          if (inv_done) begin
            d_val_r <= inv_y;
            st_r <= S_DWR;
          end
        end
        S_DWR: begin
          dec_mem[d_r] <= d_val_r;
          d_r <= d_r + 6'd1;
          if (m_r == 3'd5) begin
            m_r <= 3'd0;
            q_r <= q_r + 4'd1;
          end else m_r <= m_r + 3'd1;
          st_r <= (d_r == 6'(NSUB - 1)) ? S_IDLE : S_DRD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= rd_dec ? dec_mem[rd_addr] : enc_mem[rd_addr];
  end

  assign busy = (st_r != S_IDLE) || pend_r;
endmodule

[rtl/idea_core.sv]
// ---------------------------------------------------------------------------
// IDEA round engine
// Iterates one round per pass over subkeys streamed from the subkey memory,
// then the output transform; holds the MAC chain.
// ---------------------------------------------------------------------------
module idea_core #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  op,
  input  logic [63:0] blk,
  input  logic        restart,
  output logic        rd_en,
  output logic [5:0]  rd_addr,
  output logic        rd_dec,
  input  logic [15:0] rd_data,
  output logic        done,
  output logic [63:0] result
);
  localparam int NSUB = 6 * ROUNDS + 4;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_M1, S_M2, S_MIX, S_OUT} st_t;

  st_t         st_r;
  logic [5:0]  a_r;
  logic [2:0]  k_r;
  logic [15:0] kk_r [6];
  logic [15:0] x1_r, x2_r, x3_r, x4_r, t2_r, t1_r;
  logic [63:0] chain_r;
  logic [1:0]  op_r;
  logic        done_r;
  logic [63:0] res_r;
  logic [3:0]  rnd_r;
  logic        kv_r;

  assign rd_dec = (op_r == idea_pkg::OP_DEC);
  assign rd_en  = (st_r == S_LOAD) && (a_r < 6'(NSUB));
  assign rd_addr = a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      chain_r <= '0;
      done_r  <= 1'b0;
      kv_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (start) begin
            op_r <= op;
            a_r  <= 6'd0;
            k_r  <= 3'd0;
            rnd_r <= 4'd0;
            kv_r <= 1'b0;
            if (op == idea_pkg::OP_MAC) begin
              {x1_r, x2_r, x3_r, x4_r} <= (restart ? 64'd0 : chain_r) ^ blk;
              st_r <= S_LOAD;
            end else if (op == idea_pkg::OP_ENC || op == idea_pkg::OP_DEC) begin
              {x1_r, x2_r, x3_r, x4_r} <= blk;
              st_r <= S_LOAD;
            end else begin
              res_r  <= 64'd0;
              done_r <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          // stream six (or four) subkeys; read data arrives in the cycle after its address
          if (kv_r) begin
            kk_r[k_r] <= rd_data;
            k_r <= k_r + 3'd1;
          end
          if ((rnd_r == 4'(ROUNDS) && k_r == 3'd3 && kv_r) || (k_r == 3'd5 && kv_r)) begin
            kv_r <= 1'b0;
            st_r <= (rnd_r == 4'(ROUNDS)) ? S_OUT : S_M1;
          end else begin
            kv_r <= 1'b1;
            a_r  <= a_r + 6'd1;
          end
        end
        S_M1: begin
          x1_r <= idea_pkg::mulmod(x1_r, kk_r[0]);
          x2_r <= x2_r + kk_r[1];
          x3_r <= x3_r + kk_r[2];
          x4_r <= idea_pkg::mulmod(x4_r, kk_r[3]);
          st_r <= S_M2;
        end
        S_M2: begin
          t2_r <= idea_pkg::mulmod(x1_r ^ x3_r, kk_r[4]);
          st_r <= S_MIX;
          k_r  <= 3'd0;
        end
        S_MIX: begin
          if (k_r == 3'd0) begin
            t1_r <= idea_pkg::mulmod(t2_r + (x2_r ^ x4_r), kk_r[5]);
            k_r  <= 3'd1;
          end else begin
            x1_r <= x1_r ^ t1_r;
            x4_r <= x4_r ^ (t1_r + t2_r);
            x2_r <= x3_r ^ t1_r;
            x3_r <= (t1_r + t2_r) ^ x2_r;
            rnd_r <= rnd_r + 4'd1;
            k_r  <= 3'd0;
            st_r <= S_LOAD;
          end
        end
        S_OUT: begin
          res_r <= {idea_pkg::mulmod(x1_r, kk_r[0]), x3_r + kk_r[1],
                    x2_r + kk_r[2], idea_pkg::mulmod(x4_r, kk_r[3])};
          if (op_r == idea_pkg::OP_MAC)
            chain_r <= {idea_pkg::mulmod(x1_r, kk_r[0]), x3_r + kk_r[1],
                        x2_r + kk_r[2], idea_pkg::mulmod(x4_r, kk_r[3])};
          done_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign result = res_r;
endmodule

[rtl/idea_block_cipher_mac.sv]
// ---------------------------------------------------------------------------
// IDEA block cipher and CBC-MAC
// Encrypts, decrypts or MAC-chains 64-bit blocks under a configured key.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_op, in_block_in, in_mac_restart.
// Op 0 encrypts, 1 decrypts, 2 folds the block into the MAC chain and
// returns the new chain; op 3 returns zero. in_mac_restart clears the chain.
// Result channel: out_valid/out_stall with out_block_out, held while stalled.
// From its transfer, each block runs through the round engine before out_valid;
// the engine pulls each round's subkeys from the subkey memory one word per
// cycle, and one block is in work at a time.
// On the cfg channel, cfg_index 0 writes key_high and 1 writes key_low.
// After reset and after each key write the schedule sequencer rebuilds the
// subkeys (at 8 rounds, 52 encryption subkeys are expanded, then 52 decryption
// entries built, inverses by the inverse unit); no block is accepted while that runs.
// A result waits in the output register; the next block is accepted only
// once it is taken.
module idea_block_cipher_mac #(
  parameter int ROUNDS = idea_pkg::ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_block_in,
  input  logic        in_mac_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_block_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] kh_r, kl_r;
  logic        key_load;
  logic        busy_r, ovalid_r, kbusy, done;
  logic        rd_en, rd_dec;
  logic [5:0]  rd_addr;
  logic [15:0] rd_data;
  logic [63:0] result, obuf_r;
  logic        acc;

  assign cfg_ready = 1'b1;
  assign key_load  = cfg_valid;
  assign in_stall  = busy_r || ovalid_r || kbusy;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_r <= '0;
      kl_r <= '0;
      busy_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == idea_pkg::CFG_KEY_HIGH) kh_r <= cfg_data;
      if (cfg_valid && cfg_index == idea_pkg::CFG_KEY_LOW) kl_r <= cfg_data;
      if (acc) busy_r <= 1'b1;
      if (done) begin
        busy_r <= 1'b0;
        ovalid_r <= 1'b1;
        obuf_r <= result;
      end else if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
    end
  end

  idea_keymem #(.ROUNDS(ROUNDS)) u_keys (
    .clk(clk), .rst_n(rst_n), .key_load(key_load),
    .key({cfg_valid && cfg_index == idea_pkg::CFG_KEY_HIGH ? cfg_data : kh_r,
          cfg_valid && cfg_index == idea_pkg::CFG_KEY_LOW ? cfg_data : kl_r}),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_dec(rd_dec), .rd_data(rd_data),
    .busy(kbusy)
  );

  idea_core #(.ROUNDS(ROUNDS)) u_core (
    .clk(clk), .rst_n(rst_n), .start(acc), .op(in_op), .blk(in_block_in),
    .restart(in_mac_restart), .rd_en(rd_en), .rd_addr(rd_addr), .rd_dec(rd_dec),
    .rd_data(rd_data), .done(done), .result(result)
  );

  assign out_valid = ovalid_r;
  assign out_block_out = obuf_r;
endmodule
